### rtl/pmsp_pkg.sv
package pmsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam int SINE_SHIFT = FRAC_BITS + 1 - SINE_IDX_W;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint Q30_ONE = 64'sd1073741824;

  // pipeline schedule
  localparam int SDIV_BITS = 32 + FRAC_BITS;
  localparam int PDIV_BITS = 32;
  localparam int ST_TF = SDIV_BITS + 1;
  localparam int ST_SHAPE = ST_TF + 1;
  localparam int ST_SMUL = ST_SHAPE + 1;
  localparam int ST_SADD = ST_SMUL + 1;
  localparam int ST_PQ = PDIV_BITS + 1;
  localparam int ST_MOD0 = ST_PQ + 1;
  localparam int ST_LAST = ST_MOD0 + 32;
  localparam int PIPE_STAGES = ST_LAST + 1;

  localparam logic [2:0] MODE_CONST = 3'd0;
  localparam logic [2:0] MODE_LINEAR = 3'd1;
  localparam logic [2:0] MODE_SAW = 3'd2;
  localparam logic [2:0] MODE_TRIANGLE = 3'd3;
  localparam logic [2:0] MODE_PULSE = 3'd4;

  localparam logic [2:0] REG_FRAME_TIME = 3'd0;
  localparam logic [2:0] REG_GRAVITY_X = 3'd1;
  localparam logic [2:0] REG_GRAVITY_Y = 3'd2;
  localparam logic [2:0] REG_GRAVITY_Z = 3'd3;
  localparam logic [2:0] REG_SIZE_MODE = 3'd4;
  localparam logic [2:0] REG_SIZE_CYCLE = 3'd5;
  localparam logic [2:0] REG_PAGE_COUNT = 3'd6;
  localparam logic [2:0] REG_PAGE_TIME = 3'd7;

  typedef struct packed {
    logic [30:0]        frame_time;
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
    logic signed [31:0] gravity_z;
    logic [2:0]         size_mode;
    logic [30:0]        size_cycle_time;
    logic [7:0]         page_count;
    logic [30:0]        page_time;
  } cfg_t;

  typedef struct packed {
    logic               live;
    logic               age_pos;
    logic               age_neg;
    logic signed [31:0] elapsed;
    logic signed [31:0] life;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] angle;
    logic signed [31:0] aspeed;
    logic signed [63:0] prod_x;
    logic signed [63:0] prod_y;
    logic signed [63:0] prod_z;
    logic signed [63:0] prod_a;
    logic [63:0]        wrange;
    logic [63:0]        hrange;
    logic [SDIV_BITS-1:0] smag;
    logic [SDIV_BITS-1:0] squo;
    logic [30:0]        srem;
    logic [31:0]        pmag;
    logic [31:0]        pquo;
    logic [30:0]        prem;
    logic signed [31:0] tf;
    logic signed [63:0] wprod;
    logic signed [63:0] hprod;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic signed [31:0] fact;
    logic [31:0]        mq;
    logic [7:0]         mrem;
    logic [1:0]         status;
    logic [63:0]        size_pair;
    logic [47:0]        page_info;
  } rec_t;

  typedef logic signed [31:0] sine_tab_t [SINE_DEPTH];

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // term times x squared, Q30
  function automatic longint series_step(input longint t, input longint x);
    longint u;
    u = (t * x) / Q30_ONE;
    return (u * x) / Q30_ONE;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint x;
    longint term;
    longint sum;
    longint half_pi;
    half_pi = PI_Q30 / 2;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x = (2 * PI_Q30 * k) / SINE_DEPTH;
      if (x > half_pi && x <= 3 * half_pi) x = PI_Q30 - x;
      else if (x > 3 * half_pi) x = x - 2 * PI_Q30;
      term = x;
      sum = x;
      // taylor terms up to x^15, divisors (2n)(2n+1)
      term = -series_step(term, x) / 64'sd6;
      sum = sum + term;
      term = -series_step(term, x) / 64'sd20;
      sum = sum + term;
      term = -series_step(term, x) / 64'sd42;
      sum = sum + term;
      term = -series_step(term, x) / 64'sd72;
      sum = sum + term;
      term = -series_step(term, x) / 64'sd110;
      sum = sum + term;
      term = -series_step(term, x) / 64'sd156;
      sum = sum + term;
      term = -series_step(term, x) / 64'sd210;
      sum = sum + term;
      tab[k] = 32'((sum + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

### rtl/pmsp_if.sv
interface pmsp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] elapsed_time;
  logic [31:0] life_left;
  logic [31:0] position_x;
  logic [31:0] position_y;
  logic [31:0] position_z;
  logic [31:0] velocity_x;
  logic [31:0] velocity_y;
  logic [31:0] velocity_z;
  logic [31:0] angle;
  logic [31:0] angle_speed;
  logic [63:0] width_range;
  logic [63:0] height_range;

  modport source (output valid, elapsed_time, life_left, position_x, position_y, position_z,
                  velocity_x, velocity_y, velocity_z, angle, angle_speed, width_range,
                  height_range, input ready);
  modport sink (input valid, elapsed_time, life_left, position_x, position_y, position_z,
                velocity_x, velocity_y, velocity_z, angle, angle_speed, width_range,
                height_range, output ready);
endinterface

interface pmsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] new_elapsed_time;
  logic [31:0] new_life_left;
  logic [31:0] new_position_x;
  logic [31:0] new_position_y;
  logic [31:0] new_position_z;
  logic [31:0] new_velocity_x;
  logic [31:0] new_velocity_y;
  logic [31:0] new_velocity_z;
  logic [31:0] new_angle;
  logic [63:0] size_pair;
  logic [47:0] page_info;

  modport source (output valid, status, new_elapsed_time, new_life_left, new_position_x,
                  new_position_y, new_position_z, new_velocity_x, new_velocity_y,
                  new_velocity_z, new_angle, size_pair, page_info, input ready);
  modport sink (input valid, status, new_elapsed_time, new_life_left, new_position_x,
                new_position_y, new_position_z, new_velocity_x, new_velocity_y,
                new_velocity_z, new_angle, size_pair, page_info, output ready);
endinterface

### rtl/particle_motion_size_page_step.sv
// particle stepper: one particle record in, one advanced record out, Q16.16 throughout.
// fully pipelined, 67 register stages from input transfer to output register; a new
// record is taken every cycle while the output is free or being taken. latency is set by
// the page quotient (32 steps) followed by the page-count remainder (32 steps); the size
// quotient (48 restoring steps) runs alongside them and finishes earlier. the whole pipe
// advances together, so a stall at the output holds every stage in place.
// configuration registers are read live by every stage; write them only while the pipe
// is empty.
module particle_motion_size_page_step
  import pmsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  pmsp_in_if.sink     in_item,
  pmsp_out_if.source  out_item
);

  cfg_t cfg;
  rec_t in_rec;
  rec_t pipe [PIPE_STAGES];
  logic [PIPE_STAGES-1:0] vld;
  logic adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_time <= '0;
      cfg.gravity_x <= '0;
      cfg.gravity_y <= '0;
      cfg.gravity_z <= '0;
      cfg.size_mode <= MODE_LINEAR;
      cfg.size_cycle_time <= '0;
      cfg.page_count <= 8'd1;
      cfg.page_time <= 31'(ONE);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_TIME: cfg.frame_time <= cfg_data[30:0];
        REG_GRAVITY_X:  cfg.gravity_x <= cfg_data;
        REG_GRAVITY_Y:  cfg.gravity_y <= cfg_data;
        REG_GRAVITY_Z:  cfg.gravity_z <= cfg_data;
        REG_SIZE_MODE:  cfg.size_mode <= cfg_data[2:0];
        REG_SIZE_CYCLE: cfg.size_cycle_time <= cfg_data[30:0];
        REG_PAGE_COUNT: cfg.page_count <= cfg_data[7:0];
        REG_PAGE_TIME:  cfg.page_time <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // work done in each stage; stage number picks the slice of the schedule
  function automatic rec_t stage_fn(input rec_t r, input int j, input cfg_t c);
    rec_t o;
    logic signed [63:0] dt64;
    logic signed [65:0] dt66;
    logic [31:0] t32;
    logic [8:0]  t9;
    logic [8:0]  nx;
    logic signed [31:0] rm;
    logic [31:0] pq;
    logic [7:0]  pg;
    logic [7:0]  pn;
    o = r;
    dt64 = $signed({33'b0, c.frame_time});
    dt66 = $signed({35'b0, c.frame_time});

    if (j == 0) begin
      o.live = (r.life > 32'sd0);
      o.age_pos = (r.elapsed > 32'sd0);
      o.age_neg = r.elapsed[31];
      t32 = r.elapsed[31] ? 32'(-r.elapsed) : 32'(r.elapsed);
      o.smag = {t32, {FRAC_BITS{1'b0}}};
      o.pmag = t32;
      o.squo = '0;
      o.srem = '0;
      o.pquo = '0;
      o.prem = '0;
      o.prod_x = 64'(c.gravity_x) * dt64;
      o.prod_y = 64'(c.gravity_y) * dt64;
      o.prod_z = 64'(c.gravity_z) * dt64;
      o.prod_a = 64'(r.aspeed) * dt64;
    end

    // euler step
    if (j == 1 && r.live) begin
      o.vx = sat32(66'(r.vx) + 66'(sat32(66'(r.prod_x >>> FRAC_BITS))));
      o.vy = sat32(66'(r.vy) + 66'(sat32(66'(r.prod_y >>> FRAC_BITS))));
      o.vz = sat32(66'(r.vz) + 66'(sat32(66'(r.prod_z >>> FRAC_BITS))));
      o.angle = sat32(66'(r.angle) + 66'(sat32(66'(r.prod_a >>> FRAC_BITS))));
      o.elapsed = sat32(66'(r.elapsed) + dt66);
      o.life = sat32(66'(r.life) - dt66);
    end
    if (j == 2) begin
      o.prod_x = 64'(r.vx) * dt64;
      o.prod_y = 64'(r.vy) * dt64;
      o.prod_z = 64'(r.vz) * dt64;
    end
    if (j == 3 && r.live) begin
      o.px = sat32(66'(r.px) + 66'(sat32(66'(r.prod_x >>> FRAC_BITS))));
      o.py = sat32(66'(r.py) + 66'(sat32(66'(r.prod_y >>> FRAC_BITS))));
      o.pz = sat32(66'(r.pz) + 66'(sat32(66'(r.prod_z >>> FRAC_BITS))));
    end

    // size quotient, one bit per stage
    if (j >= 1 && j <= SDIV_BITS) begin
      t32 = {r.srem, r.smag[SDIV_BITS-1]};
      if (t32 >= {1'b0, c.size_cycle_time}) begin
        t32 = t32 - {1'b0, c.size_cycle_time};
        o.squo = {r.squo[SDIV_BITS-2:0], 1'b1};
      end else begin
        o.squo = {r.squo[SDIV_BITS-2:0], 1'b0};
      end
      o.srem = t32[30:0];
      o.smag = {r.smag[SDIV_BITS-2:0], 1'b0};
    end

    // page quotient, one bit per stage
    if (j >= 1 && j <= PDIV_BITS) begin
      t32 = {r.prem, r.pmag[31]};
      if (t32 >= {1'b0, c.page_time}) begin
        t32 = t32 - {1'b0, c.page_time};
        o.pquo = {r.pquo[30:0], 1'b1};
      end else begin
        o.pquo = {r.pquo[30:0], 1'b0};
      end
      o.prem = t32[30:0];
      o.pmag = {r.pmag[30:0], 1'b0};
    end

    if (j == ST_TF) begin
      if (c.size_cycle_time == '0) begin
        o.tf = r.age_pos ? 32'sh7FFF_FFFF : (r.age_neg ? 32'sh8000_0000 : 32'sd0);
      end else if (r.age_neg) begin
        o.tf = (r.squo > SDIV_BITS'(32'h8000_0000)) ? 32'sh8000_0000
                                                     : -$signed(r.squo[31:0]);
      end else begin
        o.tf = (r.squo > SDIV_BITS'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                     : $signed(r.squo[31:0]);
      end
    end

    if (j == ST_SHAPE) begin
      // remainder by ONE keeping the sign of tf
      if (r.tf[31] && r.tf[FRAC_BITS-1:0] != '0)
        rm = $signed({{(32-FRAC_BITS){1'b1}}, r.tf[FRAC_BITS-1:0]});
      else
        rm = $signed({{(32-FRAC_BITS){1'b0}}, r.tf[FRAC_BITS-1:0]});
      case (c.size_mode)
        MODE_LINEAR: begin
          if (r.tf > 32'(ONE)) o.tf = 32'(ONE);
        end
        MODE_SAW: o.tf = rm;
        MODE_TRIANGLE: begin
          if (rm >= 32'(ONE / 2)) rm = 32'(ONE) - rm;
          o.tf = rm <<< 1;
        end
        MODE_PULSE: o.tf = SINE_TAB[r.tf[SINE_SHIFT +: SINE_IDX_W]] + 32'(ONE / 2);
        default: ;
      endcase
    end

    if (j == ST_SMUL) begin
      o.wprod = 64'($signed(r.wrange[31:0])) * 64'(r.tf);
      o.hprod = 64'($signed(r.hrange[31:0])) * 64'(r.tf);
    end
    if (j == ST_SADD) begin
      o.w = sat32(66'($signed(r.wrange[63:32])) + 66'(sat32(66'(r.wprod >>> FRAC_BITS))));
      o.h = sat32(66'($signed(r.hrange[63:32])) + 66'(sat32(66'(r.hprod >>> FRAC_BITS))));
    end

    // signed page quotient, remainder and blend factor
    if (j == ST_PQ) begin
      if (c.page_time == '0) begin
        pq = r.age_pos ? '1 : '0;
        rm = '0;
      end else begin
        pq = r.age_neg ? '0 : r.pquo;
        rm = r.age_neg ? -$signed({1'b0, r.prem}) : $signed({1'b0, r.prem});
      end
      o.mq = pq;
      o.mrem = '0;
      o.fact = sat32(66'(ONE) - 66'(rm));
    end

    // quotient modulo page count, one bit per stage
    if (j >= ST_MOD0 && j < ST_LAST + 0 + 0 && j <= ST_MOD0 + 31) begin
      t9 = {r.mrem, r.mq[31]};
      if (t9 >= {1'b0, c.page_count}) t9 = t9 - {1'b0, c.page_count};
      o.mrem = t9[7:0];
      o.mq = {r.mq[30:0], 1'b0};
    end

    if (j == ST_LAST) begin
      nx = {1'b0, r.mrem} + 9'd1;
      if (c.page_count == '0) begin
        pg = '0;
        pn = '0;
      end else begin
        pg = r.mrem;
        pn = (nx == {1'b0, c.page_count}) ? 8'd0 : nx[7:0];
      end
      o.status = r.live ? {c.size_mode != MODE_CONST, 1'b1} : 2'b00;
      o.size_pair = (r.live && c.size_mode != MODE_CONST) ? {r.w, r.h} : '0;
      o.page_info = r.live ? {pg, pn, r.fact} : '0;
    end
    return o;
  endfunction

  always_comb begin
    in_rec = '0;
    in_rec.elapsed = in_item.elapsed_time;
    in_rec.life = in_item.life_left;
    in_rec.px = in_item.position_x;
    in_rec.py = in_item.position_y;
    in_rec.pz = in_item.position_z;
    in_rec.vx = in_item.velocity_x;
    in_rec.vy = in_item.velocity_y;
    in_rec.vz = in_item.velocity_z;
    in_rec.angle = in_item.angle;
    in_rec.aspeed = in_item.angle_speed;
    in_rec.wrange = in_item.width_range;
    in_rec.hrange = in_item.height_range;
  end

  // whole pipe moves when the output register is empty or its record is transferred
  assign adv = !vld[PIPE_STAGES-1] || out_item.ready;
  assign in_item.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_STAGES-2:0], in_item.valid};
    end
  end

  for (genvar j = 0; j < PIPE_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          pipe[0] <= stage_fn(in_rec, 0, cfg);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv) begin
          pipe[j] <= stage_fn(pipe[j-1], j, cfg);
        end
      end
    end
  end

  // output register is the last stage
  assign out_item.valid = vld[PIPE_STAGES-1];
  assign out_item.status = pipe[PIPE_STAGES-1].status;
  assign out_item.new_elapsed_time = pipe[PIPE_STAGES-1].elapsed;
  assign out_item.new_life_left = pipe[PIPE_STAGES-1].life;
  assign out_item.new_position_x = pipe[PIPE_STAGES-1].px;
  assign out_item.new_position_y = pipe[PIPE_STAGES-1].py;
  assign out_item.new_position_z = pipe[PIPE_STAGES-1].pz;
  assign out_item.new_velocity_x = pipe[PIPE_STAGES-1].vx;
  assign out_item.new_velocity_y = pipe[PIPE_STAGES-1].vy;
  assign out_item.new_velocity_z = pipe[PIPE_STAGES-1].vz;
  assign out_item.new_angle = pipe[PIPE_STAGES-1].angle;
  assign out_item.size_pair = pipe[PIPE_STAGES-1].size_pair;
  assign out_item.page_info = pipe[PIPE_STAGES-1].page_info;

endmodule
